[design/ddm_pkg.sv]
// Package for the d-pad differential drive mixer: event codes, direction codes,
// sound cue codes, register indexes, reset values and the speed-finishing function.
// No dependencies.
package ddm_pkg;

   typedef enum logic [1:0] {
      OP_DIRECTION = 2'd0,
      OP_BOOST     = 2'd1,
      OP_TICK      = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      DIR_NONE  = 4'd0,
      DIR_FWD   = 4'd1,
      DIR_BACK  = 4'd2,
      DIR_LEFT  = 4'd3,
      DIR_RIGHT = 4'd4,
      DIR_FL    = 4'd5,
      DIR_FR    = 4'd6,
      DIR_BL    = 4'd7,
      DIR_BR    = 4'd8
   } dir_type;

   typedef enum logic [1:0] {
      CUE_NONE           = 2'd0,
      CUE_BOOST_OFF      = 2'd1,
      CUE_BOOST_STRAIGHT = 2'd2,
      CUE_BOOST_TURN     = 2'd3
   } cue_type;

   typedef enum logic [2:0] {
      REG_STRAIGHT_SPEED    = 3'd0,
      REG_TURN_INNER_SPEED  = 3'd1,
      REG_TURN_OUTER_SPEED  = 3'd2,
      REG_LIGHT_INNER_SPEED = 3'd3,
      REG_LIGHT_OUTER_SPEED = 3'd4,
      REG_SLOW_SCALE        = 3'd5,
      REG_COMMAND_TIMEOUT   = 3'd6
   } csr_index_type;

   localparam int CSR_DATA_W = 24;
   localparam int IDLE_W     = 25;

   localparam logic        [6:0]  STRAIGHT_RST    = 7'd100;
   localparam logic signed [7:0]  TURN_INNER_RST  = -8'sd50;
   localparam logic signed [7:0]  TURN_OUTER_RST  = 8'sd50;
   localparam logic signed [7:0]  LIGHT_INNER_RST = 8'sd50;
   localparam logic signed [7:0]  LIGHT_OUTER_RST = 8'sd100;
   localparam logic        [7:0]  SLOW_SCALE_RST  = 8'd64;
   localparam logic        [23:0] TIMEOUT_RST     = 24'd200000;

   localparam logic signed [10:0] SPEED_MAX = 11'sd100;
   localparam logic signed [10:0] SPEED_MIN = -11'sd100;

   // Pad bits: forward, backward, left, right. Opposing pairs cancel.
   function automatic dir_type ddm_decode(input logic [3:0] pad);
      logic    fwd;
      logic    back;
      logic    left;
      logic    side;
      dir_type dir;
      fwd  = pad[0];
      back = pad[1];
      left = pad[2];
      side = pad[2] ^ pad[3];
      if (fwd == back) begin
         dir = side ? (left ? DIR_LEFT : DIR_RIGHT) : DIR_NONE;
      end else if (fwd) begin
         dir = side ? (left ? DIR_FL : DIR_FR) : DIR_FWD;
      end else begin
         dir = side ? (left ? DIR_BL : DIR_BR) : DIR_BACK;
      end
      return dir;
   endfunction

   function automatic logic ddm_is_straight(input dir_type dir);
      return (dir == DIR_NONE) || (dir == DIR_FWD) || (dir == DIR_BACK);
   endfunction

   // Scale by Q1.7 without boost (round half away from zero), then clamp to +-100.
   function automatic logic signed [7:0] ddm_finish(input logic signed [8:0] v,
                                                   input logic boost,
                                                   input logic [7:0] scale);
      logic signed [17:0] prod;
      logic        [16:0] mag;
      logic        [8:0]  quo;
      logic signed [10:0] res;
      prod = v * $signed({1'b0, scale});
      mag  = prod[17] ? 17'(-prod) : 17'(prod);
      quo  = 9'((mag + 17'd64) >> 7);
      if (boost) begin
         res = {{2{v[8]}}, v};
      end else if (prod[17]) begin
         res = -$signed({2'b00, quo});
      end else begin
         res = $signed({2'b00, quo});
      end
      if (res > SPEED_MAX) begin
         res = SPEED_MAX;
      end else if (res < SPEED_MIN) begin
         res = SPEED_MIN;
      end
      return res[7:0];
   endfunction

endpackage

[design/dpad_differential_drive_mixer.sv]
// Top level of the d-pad differential drive mixer: request register, event
// decode, speed mixing and the response register. Depends on ddm_pkg.
//
// Usage:
//   Requests arrive on the req_ channel (valid/ready): an opcode selects a
//   direction event (new pad word), a boost event (new boost state) or a time
//   tick (microseconds elapsed). Each request yields exactly one response on the
//   rsp_ channel carrying the current left/right motor speeds, whether they were
//   recomputed, the drift flag, a sound cue and a shake-change flag.
//   The csr_ port writes the seven tuning registers, one per write; write
//   them only while no request is in flight.
// Timing:
//   An accepted request is loaded into the request register and then moves through
//   the event decode and mixer into the response register, which raises rsp_valid.
//   One request per cycle is sustained while rsp_ready stays high; the event decode
//   and the mixer (one 9x9 multiply per side plus rounding and clamp) are the only
//   logic between the two registers.
// Reset:
//   Synchronous, active high. Clears the pad word, boost, drift, idle timer and
//   motor speeds, loads the register defaults and empties both stages.
// Stall:
//   When rsp_ready is low the response holds, the request register holds behind
//   it and req_ready drops once the request register is full.
module dpad_differential_drive_mixer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic [3:0]                   req_pad_bits,
   input  logic                         req_boost_on,
   input  logic [23:0]                  req_elapsed_us,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [7:0]            rsp_left_speed,
   output logic signed [7:0]            rsp_right_speed,
   output logic                         rsp_speed_updated,
   output logic                         rsp_drift_flag,
   output logic [1:0]                   rsp_sound_cue,
   output logic                         rsp_shake_change,
   input  logic                         csr_write_en,
   input  logic [2:0]                   csr_index,
   input  logic [ddm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ddm_pkg::*;

   // Tuning registers
   logic        [6:0]  straight_ff;
   logic signed [7:0]  turn_inner_ff;
   logic signed [7:0]  turn_outer_ff;
   logic signed [7:0]  light_inner_ff;
   logic signed [7:0]  light_outer_ff;
   logic        [7:0]  slow_scale_ff;
   logic        [23:0] timeout_ff;

   // Request register
   logic        req_valid_ff;
   logic [1:0]  opcode_ff;
   logic [3:0]  pad_bits_ff;
   logic        boost_on_ff;
   logic [23:0] elapsed_ff;

   // Mixer state; speeds and drift double as response payload
   logic [3:0]             pad_word_ff, pad_word_in;
   logic                   boost_ff, boost_in;
   logic                   drift_ff, drift_in;
   logic [IDLE_W-1:0]      idle_ff, idle_in;
   logic signed [7:0]      left_ff, left_in;
   logic signed [7:0]      right_ff, right_in;

   // Response register
   logic    rsp_valid_ff;
   logic    updated_ff, updated_in;
   cue_type cue_ff, cue_in;
   logic    shake_ff, shake_in;

   logic              advance;
   logic              recompute;
   dir_type           dir;
   logic              straight;
   logic signed [8:0] base_l;
   logic signed [8:0] base_r;
   logic signed [8:0] s_pos;
   logic signed [8:0] s_neg;
   logic signed [8:0] ti;
   logic signed [8:0] to;
   logic signed [8:0] li;
   logic signed [8:0] lo;
   logic              expired;

   // Advance the mixer stage whenever the response slot is free or being taken.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;

   // ---------------------------------------------------------------------------
   // Event decode: pick the next pad word and boost state, then drift and cues.
   // ---------------------------------------------------------------------------
   assign expired = (idle_ff >= {1'b0, timeout_ff});

   always_comb begin
      pad_word_in = pad_word_ff;
      boost_in    = boost_ff;
      drift_in    = drift_ff;
      idle_in     = idle_ff;
      recompute   = 1'b0;
      cue_in      = CUE_NONE;
      shake_in    = 1'b0;
      case (opcode_type'(opcode_ff))
         OP_DIRECTION: begin
            pad_word_in = pad_bits_ff;
            idle_in     = '0;
            recompute   = 1'b1;
         end
         OP_BOOST: begin
            boost_in  = boost_on_ff;
            shake_in  = boost_on_ff != boost_ff;
            recompute = 1'b1;
         end
         OP_TICK: begin
            if (expired && (pad_word_ff != 4'd0)) begin
               pad_word_in = 4'd0;
               recompute   = 1'b1;
            end else if (idle_ff <= {1'b0, timeout_ff}) begin
               idle_in = IDLE_W'(idle_ff + {1'b0, elapsed_ff});
            end
         end
         default: begin
         end
      endcase

      dir      = ddm_decode(pad_word_in);
      straight = ddm_is_straight(dir);

      case (opcode_type'(opcode_ff))
         OP_DIRECTION: begin
            if (drift_ff && boost_ff && straight) begin
               drift_in = 1'b0;
               cue_in   = CUE_BOOST_STRAIGHT;
            end else if (!drift_ff && boost_ff && !straight) begin
               drift_in = 1'b1;
               cue_in   = CUE_BOOST_TURN;
            end
         end
         OP_BOOST: begin
            if (!boost_on_ff) begin
               drift_in = 1'b0;
               cue_in   = CUE_BOOST_OFF;
            end else if (straight) begin
               drift_in = 1'b0;
               cue_in   = CUE_BOOST_STRAIGHT;
            end else begin
               drift_in = 1'b1;
               cue_in   = CUE_BOOST_TURN;
            end
         end
         default: begin
         end
      endcase
      updated_in = recompute;
   end

   // ---------------------------------------------------------------------------
   // Speed mixing: per-side base speed from the direction, then scale and clamp.
   // ---------------------------------------------------------------------------
   assign s_pos = $signed({2'b00, straight_ff});
   assign s_neg = 9'(-s_pos);
   assign ti    = {turn_inner_ff[7], turn_inner_ff};
   assign to    = {turn_outer_ff[7], turn_outer_ff};
   assign li    = {light_inner_ff[7], light_inner_ff};
   assign lo    = {light_outer_ff[7], light_outer_ff};

   always_comb begin
      case (dir)
         DIR_FWD: begin
            base_l = s_pos;
            base_r = s_pos;
         end
         DIR_BACK: begin
            base_l = s_neg;
            base_r = s_neg;
         end
         DIR_LEFT: begin
            base_l = ti;
            base_r = to;
         end
         DIR_RIGHT: begin
            base_l = to;
            base_r = ti;
         end
         DIR_FL: begin
            base_l = li;
            base_r = lo;
         end
         DIR_FR: begin
            base_l = lo;
            base_r = li;
         end
         DIR_BL: begin
            base_l = 9'(-lo);
            base_r = 9'(-li);
         end
         DIR_BR: begin
            base_l = 9'(-li);
            base_r = 9'(-lo);
         end
         default: begin
            base_l = '0;
            base_r = '0;
         end
      endcase
      left_in  = recompute ? ddm_finish(base_l, boost_in, slow_scale_ff) : left_ff;
      right_in = recompute ? ddm_finish(base_r, boost_in, slow_scale_ff) : right_ff;
   end

   // ---------------------------------------------------------------------------
   // Tuning registers: one register per write, unknown indexes dropped.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         straight_ff    <= STRAIGHT_RST;
         turn_inner_ff  <= TURN_INNER_RST;
         turn_outer_ff  <= TURN_OUTER_RST;
         light_inner_ff <= LIGHT_INNER_RST;
         light_outer_ff <= LIGHT_OUTER_RST;
         slow_scale_ff  <= SLOW_SCALE_RST;
         timeout_ff     <= TIMEOUT_RST;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_STRAIGHT_SPEED:    straight_ff    <= csr_wdata[6:0];
            REG_TURN_INNER_SPEED:  turn_inner_ff  <= csr_wdata[7:0];
            REG_TURN_OUTER_SPEED:  turn_outer_ff  <= csr_wdata[7:0];
            REG_LIGHT_INNER_SPEED: light_inner_ff <= csr_wdata[7:0];
            REG_LIGHT_OUTER_SPEED: light_outer_ff <= csr_wdata[7:0];
            REG_SLOW_SCALE:        slow_scale_ff  <= csr_wdata[7:0];
            REG_COMMAND_TIMEOUT:   timeout_ff     <= csr_wdata[23:0];
            default: begin
            end
         endcase
      end
   end

   // Request register: capture on accept, drop once passed to the mixer.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         opcode_ff   <= req_opcode;
         pad_bits_ff <= req_pad_bits;
         boost_on_ff <= req_boost_on;
         elapsed_ff  <= req_elapsed_us;
      end
   end

   // Mixer state and response register advance together.
   always_ff @(posedge clock) begin
      if (reset) begin
         pad_word_ff  <= '0;
         boost_ff     <= 1'b0;
         drift_ff     <= 1'b0;
         idle_ff      <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            pad_word_ff <= pad_word_in;
            boost_ff    <= boost_in;
            drift_ff    <= drift_in;
            idle_ff     <= idle_in;
            left_ff     <= left_in;
            right_ff    <= right_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid_ff) begin
         updated_ff <= updated_in;
         cue_ff     <= cue_in;
         shake_ff   <= shake_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_speed    = left_ff;
   assign rsp_right_speed   = right_ff;
   assign rsp_speed_updated = updated_ff;
   assign rsp_drift_flag    = drift_ff;
   assign rsp_sound_cue     = cue_ff;
   assign rsp_shake_change  = shake_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_drift_needs_boost: assert property (@(posedge clock) disable iff (reset)
      drift_ff |-> boost_ff)
      else $error("drift flag set without boost");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      (left_ff >= -8'sd100) && (left_ff <= 8'sd100) &&
      (right_ff >= -8'sd100) && (right_ff <= 8'sd100))
      else $error("motor speed outside +-100");

   a_idle_pad_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && updated_ff && (pad_word_ff == 4'd0)) |->
      ((left_ff == 8'sd0) && (right_ff == 8'sd0)))
      else $error("released pad left motors running");

   a_shake_has_cue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && shake_ff) |-> (cue_ff != CUE_NONE) && updated_ff)
      else $error("boost change reported without a cue");

endmodule

[bench/tb_dpad_differential_drive_mixer.sv]
// Self-checking bench for the d-pad differential drive mixer: a directed table, then
// random event streams over several register settings, checked against a predictor.
// Depends on ddm_pkg and dpad_differential_drive_mixer.
module tb_dpad_differential_drive_mixer;
   timeunit 1ns;
   timeprecision 1ps;

   import ddm_pkg::*;

   // The event code the block leaves unused: it must change nothing.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 60;
   localparam int PHASE_ITEMS   = 100;
   localparam int NUM_PHASES    = 7;
   localparam int NUM_DIRECTED  = 25;

   typedef struct packed {
      logic signed [7:0] lspd;
      logic signed [7:0] rspd;
      logic              updated;
      logic              drift;
      cue_type           cue;
      logic              shake;
   } mixer_result_type;

   typedef struct {
      logic [1:0]       op;
      logic [3:0]       pad;
      logic             boost;
      logic [23:0]      elapsed;
      bit               typed;
      mixer_result_type want;
   } drive_row_type;

   typedef struct {
      bit               typed;
      mixer_result_type want;
   } preset_type;

   localparam mixer_result_type NO_RESULT = '0;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_opcode;
   logic [3:0] req_pad_bits;
   logic req_boost_on;
   logic [23:0] req_elapsed_us;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [7:0] rsp_left_speed;
   logic signed [7:0] rsp_right_speed;
   logic rsp_speed_updated;
   logic rsp_drift_flag;
   logic [1:0] rsp_sound_cue;
   logic rsp_shake_change;
   logic csr_write_en;
   logic [2:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Mixer settings as the bench believes them to be.
   logic        [6:0]  straight_cfg  = STRAIGHT_RST;
   logic signed [7:0]  turn_in_cfg   = TURN_INNER_RST;
   logic signed [7:0]  turn_out_cfg  = TURN_OUTER_RST;
   logic signed [7:0]  light_in_cfg  = LIGHT_INNER_RST;
   logic signed [7:0]  light_out_cfg = LIGHT_OUTER_RST;
   logic        [7:0]  scale_cfg     = SLOW_SCALE_RST;
   logic        [23:0] timeout_cfg   = TIMEOUT_RST;

   // Mixer state as the bench tracks it.
   logic [3:0]         pad_st   = '0;
   logic               boost_st = 1'b0;
   logic               drift_st = 1'b0;
   dir_type            dir_st   = DIR_NONE;
   logic [IDLE_W-1:0]  idle_st  = '0;
   logic signed [7:0]  lspd_st  = '0;
   logic signed [7:0]  rspd_st  = '0;

   mixer_result_type expect_q[$];
   preset_type       preset_q[$];
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   int               holds_asked = 0;
   int               burst_left = 0;
   int               el_span = 1;

   dpad_differential_drive_mixer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_pad_bits      (req_pad_bits),
      .req_boost_on      (req_boost_on),
      .req_elapsed_us    (req_elapsed_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_speed    (rsp_left_speed),
      .rsp_right_speed   (rsp_right_speed),
      .rsp_speed_updated (rsp_speed_updated),
      .rsp_drift_flag    (rsp_drift_flag),
      .rsp_sound_cue     (rsp_sound_cue),
      .rsp_shake_change  (rsp_shake_change),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // Opposing pad bits cancel each other; what is left picks one of nine directions.
   function automatic dir_type pad_dir(input logic [3:0] pad);
      logic fwd_only;
      logic back_only;
      logic left_only;
      logic right_only;
      fwd_only   = pad[0] & ~pad[1];
      back_only  = pad[1] & ~pad[0];
      left_only  = pad[2] & ~pad[3];
      right_only = pad[3] & ~pad[2];
      if (fwd_only) begin
         return left_only ? DIR_FL : (right_only ? DIR_FR : DIR_FWD);
      end else if (back_only) begin
         return left_only ? DIR_BL : (right_only ? DIR_BR : DIR_BACK);
      end
      return left_only ? DIR_LEFT : (right_only ? DIR_RIGHT : DIR_NONE);
   endfunction

   function automatic bit dir_is_level(input dir_type dir);
      return dir == DIR_NONE || dir == DIR_FWD || dir == DIR_BACK;
   endfunction

   // Scale by the Q1.7 factor unless boosting, round half away from zero, clamp.
   function automatic logic signed [7:0] side_speed(input int raw);
      int prod;
      int mag;
      int quo;
      int res;
      if (boost_st) begin
         res = raw;
      end else begin
         prod = raw * int'(scale_cfg);
         mag  = (prod < 0) ? -prod : prod;
         quo  = (mag + 64) >>> 7;
         res  = (prod < 0) ? -quo : quo;
      end
      if (res > 100) begin
         res = 100;
      end else if (res < -100) begin
         res = -100;
      end
      return 8'(res);
   endfunction

   // Decode the pad word and pick both side speeds; reverse diagonals swap and negate.
   function automatic void remix();
      int lv;
      int rv;
      int s;
      s  = int'(straight_cfg);
      lv = 0;
      rv = 0;
      dir_st = pad_dir(pad_st);
      case (dir_st)
         DIR_FWD: begin
            lv = s;
            rv = s;
         end
         DIR_BACK: begin
            lv = -s;
            rv = -s;
         end
         DIR_LEFT: begin
            lv = int'(turn_in_cfg);
            rv = int'(turn_out_cfg);
         end
         DIR_RIGHT: begin
            lv = int'(turn_out_cfg);
            rv = int'(turn_in_cfg);
         end
         DIR_FL: begin
            lv = int'(light_in_cfg);
            rv = int'(light_out_cfg);
         end
         DIR_FR: begin
            lv = int'(light_out_cfg);
            rv = int'(light_in_cfg);
         end
         DIR_BL: begin
            lv = -int'(light_out_cfg);
            rv = -int'(light_in_cfg);
         end
         DIR_BR: begin
            lv = -int'(light_in_cfg);
            rv = -int'(light_out_cfg);
         end
         default: begin
         end
      endcase
      lspd_st = side_speed(lv);
      rspd_st = side_speed(rv);
   endfunction

   // Advance the tracked state by one event and return the response it should produce.
   function automatic mixer_result_type mixer_event(input logic [1:0] op,
                                                    input logic [3:0] pad,
                                                    input logic boost,
                                                    input logic [23:0] elapsed);
      mixer_result_type res;
      res = NO_RESULT;
      case (op)
         OP_DIRECTION: begin
            pad_st  = pad;
            idle_st = '0;
            remix();
            res.updated = 1'b1;
            if (drift_st && boost_st && dir_is_level(dir_st)) begin
               drift_st = 1'b0;
               res.cue  = CUE_BOOST_STRAIGHT;
            end else if (!drift_st && boost_st && !dir_is_level(dir_st)) begin
               drift_st = 1'b1;
               res.cue  = CUE_BOOST_TURN;
            end
         end
         OP_BOOST: begin
            res.shake = (boost != boost_st);
            boost_st  = boost;
            remix();
            res.updated = 1'b1;
            if (!boost_st) begin
               drift_st = 1'b0;
               res.cue  = CUE_BOOST_OFF;
            end else if (dir_is_level(dir_st)) begin
               drift_st = 1'b0;
               res.cue  = CUE_BOOST_STRAIGHT;
            end else begin
               drift_st = 1'b1;
               res.cue  = CUE_BOOST_TURN;
            end
         end
         OP_TICK: begin
            if (idle_st >= {1'b0, timeout_cfg} && pad_st != '0) begin
               pad_st = '0;
               remix();
               res.updated = 1'b1;
            end else if (idle_st <= {1'b0, timeout_cfg}) begin
               idle_st = idle_st + {1'b0, elapsed};
            end
         end
         default: begin
         end
      endcase
      res.lspd  = lspd_st;
      res.rspd  = rspd_st;
      res.drift = drift_st;
      return res;
   endfunction

   function automatic void compare_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   // Directed events under the reset settings: every direction, the pad conflicts,
   // boost on and off, drift entry and exit, the timeout at and past its limit, the
   // largest tick and the unused event code.
   drive_row_type directed_rows [NUM_DIRECTED] = '{
      '{OP_TICK,      4'h0, 1'b0, 24'h000000, 1'b1,
        '{8'sd0, 8'sd0, 1'b0, 1'b0, CUE_NONE, 1'b0}},
      '{OP_DIRECTION, 4'h1, 1'b0, 24'h000000, 1'b1,
        '{8'sd50, 8'sd50, 1'b1, 1'b0, CUE_NONE, 1'b0}},
      '{OP_DIRECTION, 4'h2, 1'b1, 24'hFFFFFF, 1'b1,
        '{-8'sd50, -8'sd50, 1'b1, 1'b0, CUE_NONE, 1'b0}},
      '{OP_DIRECTION, 4'h4, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_BOOST,     4'hF, 1'b1, 24'hFFFFFF, 1'b1,
        '{-8'sd50, 8'sd50, 1'b1, 1'b1, CUE_BOOST_TURN, 1'b1}},
      '{OP_DIRECTION, 4'h5, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_DIRECTION, 4'h3, 1'b0, 24'h000000, 1'b1,
        '{8'sd0, 8'sd0, 1'b1, 1'b0, CUE_BOOST_STRAIGHT, 1'b0}},
      '{OP_DIRECTION, 4'h9, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_DIRECTION, 4'h6, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_DIRECTION, 4'hA, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_DIRECTION, 4'h8, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_DIRECTION, 4'hD, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_BOOST,     4'h0, 1'b1, 24'h000000, 1'b0, NO_RESULT},
      '{OP_BOOST,     4'h0, 1'b0, 24'h000000, 1'b1,
        '{8'sd50, 8'sd50, 1'b1, 1'b0, CUE_BOOST_OFF, 1'b1}},
      '{OP_BOOST,     4'h0, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_DIRECTION, 4'hE, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_DIRECTION, 4'hF, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_DIRECTION, 4'h7, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_TICK,      4'h0, 1'b0, 24'hFFFFFF, 1'b0, NO_RESULT},
      '{OP_TICK,      4'h0, 1'b0, 24'h000000, 1'b1,
        '{8'sd0, 8'sd0, 1'b1, 1'b0, CUE_NONE, 1'b0}},
      '{OP_TICK,      4'h0, 1'b0, 24'hFFFFFF, 1'b1,
        '{8'sd0, 8'sd0, 1'b0, 1'b0, CUE_NONE, 1'b0}},
      '{OP_UNUSED,    4'hF, 1'b1, 24'hFFFFFF, 1'b1,
        '{8'sd0, 8'sd0, 1'b0, 1'b0, CUE_NONE, 1'b0}},
      '{OP_DIRECTION, 4'h1, 1'b0, 24'h000000, 1'b0, NO_RESULT},
      '{OP_TICK,      4'h0, 1'b0, 24'd199999, 1'b0, NO_RESULT},
      '{OP_TICK,      4'h0, 1'b0, 24'd1,      1'b0, NO_RESULT}
   };

   // Offer one request in the sender's burst pattern: between bursts drop valid for a
   // random gap, otherwise hold valid high and move straight on to the next payload.
   task automatic offer(input logic [1:0] op, input logic [3:0] pad, input logic boost,
                        input logic [23:0] elapsed, input bit typed,
                        input mixer_result_type want);
      int gap;
      preset_type tag;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      tag.typed = typed;
      tag.want  = want;
      preset_q.push_back(tag);
      req_valid      = 1'b1;
      req_opcode     = op;
      req_pad_bits   = pad;
      req_boost_on   = boost;
      req_elapsed_us = elapsed;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
   endtask

   // Drop valid and wait until every expected response has come back.
   task automatic drain();
      req_valid  = 1'b0;
      burst_left = 0;
      while (expect_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      @(posedge clock);
      case (idx)
         REG_STRAIGHT_SPEED:    straight_cfg  = data[6:0];
         REG_TURN_INNER_SPEED:  turn_in_cfg   = data[7:0];
         REG_TURN_OUTER_SPEED:  turn_out_cfg  = data[7:0];
         REG_LIGHT_INNER_SPEED: light_in_cfg  = data[7:0];
         REG_LIGHT_OUTER_SPEED: light_out_cfg = data[7:0];
         REG_SLOW_SCALE:        scale_cfg     = data[7:0];
         REG_COMMAND_TIMEOUT:   timeout_cfg   = data[23:0];
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   // Load all seven tuning registers; call only with the block idle.
   task automatic load_settings(input int s, input int ti, input int to, input int li,
                                input int lo, input int sc, input int tmo);
      write_csr(REG_STRAIGHT_SPEED,    24'(s & 'h7F));
      write_csr(REG_TURN_INNER_SPEED,  24'(ti & 'hFF));
      write_csr(REG_TURN_OUTER_SPEED,  24'(to & 'hFF));
      write_csr(REG_LIGHT_INNER_SPEED, 24'(li & 'hFF));
      write_csr(REG_LIGHT_OUTER_SPEED, 24'(lo & 'hFF));
      write_csr(REG_SLOW_SCALE,        24'(sc & 'hFF));
      write_csr(REG_COMMAND_TIMEOUT,   24'(tmo));
      csr_write_en = 1'b0;
      // Keep ticks short enough relative to the timeout that drives do time out.
      el_span = tmo / 4 + 1;
   endtask

   // Mostly direction changes, boost toggles and ticks; a rare unused code as noise.
   task automatic random_request();
      int pick;
      logic [1:0] op;
      logic [23:0] elapsed;
      pick = $urandom_range(0, 15);
      if (pick <= 6) begin
         op = OP_DIRECTION;
      end else if (pick <= 9) begin
         op = OP_BOOST;
      end else if (pick <= 14) begin
         op = OP_TICK;
      end else begin
         op = OP_UNUSED;
      end
      if ($urandom_range(0, 7) == 0) begin
         elapsed = 24'($urandom);
      end else begin
         elapsed = 24'($urandom_range(0, el_span));
      end
      offer(op, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), elapsed, 1'b0, NO_RESULT);
   endtask

   // Predict on every accepted request, and check every accepted response in order.
   always @(posedge clock) begin : scoreboard
      mixer_result_type want;
      mixer_result_type got;
      preset_type tag;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = mixer_event(req_opcode, req_pad_bits, req_boost_on, req_elapsed_us);
            tag  = preset_q.pop_front();
            if (tag.typed) begin
               want = tag.want;
            end
            expect_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_left_speed, rsp_right_speed, rsp_speed_updated, rsp_drift_flag,
                    cue_type'(rsp_sound_cue), rsp_shake_change};
            if (expect_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = expect_q.pop_front();
               compare_field("left_speed", int'(want.lspd), int'(got.lspd));
               compare_field("right_speed", int'(want.rspd), int'(got.rspd));
               compare_field("speed_updated", int'(want.updated), int'(got.updated));
               compare_field("drift_flag", int'(want.drift), int'(got.drift));
               compare_field("sound_cue", int'(want.cue), int'(got.cue));
               compare_field("shake_change", int'(want.shake), int'(got.shake));
            end
         end
      end
   end

   // Stop the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb_dpad_differential_drive_mixer: done, errors");
         $finish;
      end
   end

   // Receiver: switch between stall patterns at random; on request hold off for a long
   // stretch so the block backs up into its request side.
   initial begin : receiver
      int mode;
      int mode_left;
      int hold_left;
      int holds_seen;
      mode       = 0;
      mode_left  = 0;
      hold_left  = 0;
      holds_seen = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_seen != holds_asked) begin
            holds_seen = holds_asked;
            hold_left  = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(1, 80);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            case (mode)
               0: rsp_ready = 1'b1;
               1: rsp_ready = 1'($urandom_range(0, 1));
               2: rsp_ready = ($urandom_range(0, 3) == 0);
               default: rsp_ready = ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_DIRECTION;
      req_pad_bits   = '0;
      req_boost_on   = 1'b0;
      req_elapsed_us = '0;
      csr_write_en   = 1'b0;
      csr_index      = REG_STRAIGHT_SPEED;
      csr_wdata      = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table under the reset settings.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         offer(directed_rows[i].op, directed_rows[i].pad, directed_rows[i].boost,
               directed_rows[i].elapsed, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases: all registers at their top, all at their bottom, then random.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         case (phase)
            0: load_settings(127, 127, 127, 127, 127, 255, 24'hFFFFFF);
            1: load_settings(0, -127, -127, -127, -127, 0, 0);
            default: begin
               load_settings($urandom_range(0, 127),
                             int'($urandom_range(0, 254)) - 127,
                             int'($urandom_range(0, 254)) - 127,
                             int'($urandom_range(0, 254)) - 127,
                             int'($urandom_range(0, 254)) - 127,
                             $urandom_range(0, 255),
                             (phase % 2 == 0) ? $urandom_range(0, 4000)
                                              : $urandom_range(0, 24'hFFFFFF));
            end
         endcase
         // Stall the receiver long enough to fill the block while requests keep coming.
         if (phase == 2) begin
            holds_asked++;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) begin
               drain();
            end
            random_request();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expect_q.size() == 0) begin
         $display("tb_dpad_differential_drive_mixer: done, clean");
      end else begin
         $display("tb_dpad_differential_drive_mixer: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
design/ddm_pkg.sv
design/dpad_differential_drive_mixer.sv
bench/tb_dpad_differential_drive_mixer.sv
